@@ rtl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, codes and register layout for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TICK_W    = 8;
    localparam int ELAPSED_W = 16;
    localparam int HOLD_W    = 8;
    localparam int CODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    typedef logic [CODE_W-1:0] t_code;

    // status codes
    localparam t_code ST_NOT_PRESSED = 2'd0;
    localparam t_code ST_ONE_CLICK   = 2'd1;
    localparam t_code ST_HELD        = 2'd2;

    // event codes
    localparam t_code EV_NONE  = 2'd0;
    localparam t_code EV_SHORT = 2'd1;
    localparam t_code EV_LONG  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_WINDOW = 2'd2;

    // register reset values
    localparam logic [TICK_W-1:0]    RST_SAMPLE_PERIOD  = 8'd50;
    localparam logic [HOLD_W-1:0]    RST_HOLD_THRESHOLD = 8'd60;
    localparam logic [ELAPSED_W-1:0] RST_RELEASE_WINDOW = 16'd200;

    typedef struct packed {
        logic [TICK_W-1:0]    sample_period;
        logic [HOLD_W-1:0]    hold_threshold;
        logic [ELAPSED_W-1:0] release_window;
    } t_bpc_cfg;

    typedef struct packed {
        logic [TICK_W-1:0]    tick_count;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 armed;
        logic                 window_running;
        t_code                status;
        logic [HOLD_W-1:0]    hold_count;
    } t_bpc_state;

endpackage

@@ rtl/bpc_query.sv @@
// ----------------------------------------------------------------------------
// bpc_query
// Next-state and event logic for one millisecond tick.
// ----------------------------------------------------------------------------
module bpc_query import bpc_pkg::*; (
    input  t_bpc_state i_state,
    input  t_bpc_cfg   i_cfg,
    input  logic       i_level,
    output t_bpc_state o_state,
    output t_code      o_event
);

    logic [TICK_W:0] tick_next;
    logic            run_query;
    logic            window_passed;
    logic            held_enough;

    always_comb begin
        o_state   = i_state;
        o_event   = EV_NONE;
        held_enough   = 1'b0;
        window_passed = 1'b0;

        // saturating elapsed time
        if (i_state.elapsed_ms != {ELAPSED_W{1'b1}}) begin
            o_state.elapsed_ms = i_state.elapsed_ms + 1'b1;
        end

        // prescaler compared at one bit wider
        tick_next = {1'b0, i_state.tick_count} + 1'b1;
        run_query = tick_next > {1'b0, i_cfg.sample_period};

        if (run_query) begin
            o_state.tick_count = '0;

            // armed first press opens the window
            if (o_state.armed && i_level) begin
                o_state.armed = 1'b0;
                if (!o_state.window_running) begin
                    o_state.window_running = 1'b1;
                    o_state.status         = ST_ONE_CLICK;
                    o_state.elapsed_ms     = '0;
                end
            end

            // count pressed samples
            if (o_state.status == ST_ONE_CLICK || o_state.status == ST_HELD) begin
                if (i_level && o_state.hold_count != {HOLD_W{1'b1}}) begin
                    o_state.hold_count = o_state.hold_count + 1'b1;
                end
                if (o_state.hold_count >= i_cfg.hold_threshold) begin
                    o_state.status = ST_HELD;
                end
            end

            // decide once the window has passed
            window_passed = o_state.window_running &&
                            (o_state.elapsed_ms > i_cfg.release_window);
            held_enough   = o_state.hold_count >= i_cfg.hold_threshold;
            if (window_passed) begin
                if (i_level && held_enough && o_state.status == ST_HELD) begin
                    o_event            = EV_LONG;
                    o_state.hold_count = '0;
                end
                if (!i_level) begin
                    if (o_state.status == ST_ONE_CLICK) begin
                        o_event = EV_SHORT;
                    end
                    o_state.armed          = 1'b1;
                    o_state.window_running = 1'b0;
                    o_state.hold_count     = '0;
                    o_state.status         = ST_NOT_PRESSED;
                end
            end

            // release with no window re-arms
            if (!i_level && !o_state.window_running) begin
                o_state.armed          = 1'b1;
                o_state.window_running = 1'b0;
                o_state.hold_count     = '0;
                o_state.status         = ST_NOT_PRESSED;
            end
        end else begin
            o_state.tick_count = tick_next[TICK_W-1:0];
        end
    end

endmodule

@@ rtl/button_press_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// Short / long press classifier for a push button sampled once per ms tick.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the button level; every
// beat gives exactly one output beat with the event of that tick (none,
// short or long press) and the status after it. The block takes one beat
// per clock as long as the output side keeps taking beats: the tick is
// folded into the state registers in the cycle it is accepted, and its
// result lands in a single output register. A stalled output holds the
// result register and the input side then waits, at most one result is
// buffered. A button query runs every sample_period+1 ticks; hold_threshold
// pressed queries make a hold, and events are decided once release_window
// ms have passed since the first press. Configuration is taken on any
// cycle with i_cfg_we high; index 0 sample_period, 1 hold_threshold, 2
// release_window, other indexes are ignored. Writes should be made while
// no beat is in flight.
// ----------------------------------------------------------------------------
module button_press_classifier_unit import bpc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]   i_cfg_data,
    // tick input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] button_level, rest zero
    // result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [1:0] press_event, [3:2] press_status
);

    t_bpc_cfg   r_cfg;
    t_bpc_state r_state;
    t_bpc_state n_state;
    t_code      n_event;
    logic       r_out_valid;
    t_code      r_out_event;
    t_code      r_out_status;
    logic       in_beat;

    // result register frees up when it is empty or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period  <= RST_SAMPLE_PERIOD;
            r_cfg.hold_threshold <= RST_HOLD_THRESHOLD;
            r_cfg.release_window <= RST_RELEASE_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SAMPLE_PERIOD:  r_cfg.sample_period  <= i_cfg_data[TICK_W-1:0];
                REG_HOLD_THRESHOLD: r_cfg.hold_threshold <= i_cfg_data[HOLD_W-1:0];
                REG_RELEASE_WINDOW: r_cfg.release_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-tick update logic
    bpc_query u_query (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_level (s_axis_tdata[0]),
        .o_state (n_state),
        .o_event (n_event)
    );

    // classifier state, updated on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tick_count     <= '0;
            r_state.elapsed_ms     <= '0;
            r_state.armed          <= 1'b0;
            r_state.window_running <= 1'b0;
            r_state.status         <= ST_ONE_CLICK;
            r_state.hold_count     <= '0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_event  <= n_event;
            r_out_status <= n_state.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-2*CODE_W){1'b0}}, r_out_status, r_out_event};

`ifndef SYNTHESIS
    // an open window always means the first press was consumed
    a_window_not_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.window_running |-> !r_state.armed)
        else $error("window open while still armed");

    // armed only in the not-pressed status
    a_armed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed |-> r_state.status == ST_NOT_PRESSED)
        else $error("armed outside not-pressed status");

    // long press only reported with held status
    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_event == EV_LONG |-> r_out_status == ST_HELD)
        else $error("long press without held status");

    // short press re-arms the detector in the same beat
    a_short_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_event == EV_SHORT && $past(in_beat)
        |-> r_out_status == ST_NOT_PRESSED && r_state.armed)
        else $error("short press did not re-arm");
`endif

endmodule

@@ test/tb_button_press_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_classifier_unit
// Self-checking bench for the short / long press classifier.
// ----------------------------------------------------------------------------
// Every tick beat sent in is run through a behavioral copy of the classifier
// held in this bench. Its event and status are queued and compared, in
// order, with each result beat taken from the block. A few directed
// sequences come first: reset values, short and long presses, zero
// settings, and counter saturation. They are followed by randomized press
// and release runs under a range of register settings. Both handshakes idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_button_press_classifier_unit;
    import bpc_pkg::*;

    localparam longint TIMEOUT_NS = 64'd40_000_000;

    typedef struct {
        t_code press_event;
        t_code press_status;
    } t_press_report;

    // clock, reset and block inputs, all known from time zero
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = REG_SAMPLE_PERIOD;
    logic [CFG_DAT_W-1:0]   i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [0] button_level, rest zero
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [1:0] press_event, [3:2] press_status

    // reports still owed by the block, oldest first
    t_press_report pending_reports[$];
    int            err_cnt = 0;
    bit            idle_on = 1'b1;   // random gaps on both sides when set

    // classifier copy: settings
    logic [TICK_W-1:0]    cls_period = RST_SAMPLE_PERIOD;
    logic [HOLD_W-1:0]    cls_thresh = RST_HOLD_THRESHOLD;
    logic [ELAPSED_W-1:0] cls_window = RST_RELEASE_WINDOW;
    // classifier copy: state
    logic [TICK_W-1:0]    cls_tick    = '0;
    logic [ELAPSED_W-1:0] cls_elapsed = '0;
    logic                 cls_armed   = 1'b0;
    logic                 cls_win_run = 1'b0;
    t_code                cls_status  = ST_ONE_CLICK;
    logic [HOLD_W-1:0]    cls_hold    = '0;

    button_press_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // classifier copy
    // ------------------------------------------------------------------

    // back to not pressed, ready for a new first press
    function automatic void rearm_detector();
        cls_armed   = 1'b1;
        cls_win_run = 1'b0;
        cls_hold    = '0;
        cls_status  = ST_NOT_PRESSED;
    endfunction

    // one button query, returns the event code
    function automatic t_code run_query(input logic lvl);
        t_code ev = EV_NONE;
        // first press after arming opens the release window
        if (cls_armed && lvl) begin
            cls_armed = 1'b0;
            if (!cls_win_run) begin
                cls_win_run = 1'b1;
                cls_status  = ST_ONE_CLICK;
                cls_elapsed = '0;
            end
        end
        // pressed samples are counted while clicked or held, saturating
        if (cls_status == ST_ONE_CLICK || cls_status == ST_HELD) begin
            if (lvl && cls_hold != '1)
                cls_hold = cls_hold + 1'b1;
            if (cls_hold >= cls_thresh)
                cls_status = ST_HELD;
        end
        // window passed: decide the event
        if (cls_win_run && cls_elapsed > cls_window) begin
            if (lvl && cls_hold >= cls_thresh && cls_status == ST_HELD) begin
                ev       = EV_LONG;
                cls_hold = '0;
            end
            if (!lvl) begin
                if (cls_status == ST_ONE_CLICK)
                    ev = EV_SHORT;
                rearm_detector();
            end
        end
        // release with no window open
        if (!lvl && !cls_win_run)
            rearm_detector();
        return ev;
    endfunction

    // one millisecond tick: prescaler, elapsed time, maybe a query
    function automatic t_press_report classify_tick(input logic lvl);
        logic [TICK_W:0] nxt;
        t_press_report   rep;
        nxt = {1'b0, cls_tick} + 1'b1;
        if (cls_elapsed != '1)
            cls_elapsed = cls_elapsed + 1'b1;
        rep.press_event = EV_NONE;
        // prescaler compares one bit wider so a period of 255 still wraps
        if (nxt > {1'b0, cls_period}) begin
            cls_tick        = '0;
            rep.press_event = run_query(lvl);
        end else begin
            cls_tick = nxt[TICK_W-1:0];
        end
        rep.press_status = cls_status;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------

    function automatic int pick_stall_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    int rdy_left = 0;
    always @(posedge i_clk) begin
        if (rdy_left > 0) begin
            rdy_left--;
        end else if (!idle_on || !m_axis_tready) begin
            // open up for a run of beats
            m_axis_tready <= 1'b1;
            rdy_left = idle_on ? $urandom_range(0, 24) : 0;
        end else begin
            // stall
            m_axis_tready <= 1'b0;
            rdy_left = pick_stall_len();
        end
    end

    // each result beat is checked against the oldest pending report
    always @(posedge i_clk) begin
        t_press_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with no report pending: tdata %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = pending_reports.pop_front();
                if (m_axis_tdata[1:0] !== want.press_event) begin
                    $error("press_event mismatch: expected %0d, got %0d",
                           want.press_event, m_axis_tdata[1:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[3:2] !== want.press_status) begin
                    $error("press_status mismatch: expected %0d, got %0d",
                           want.press_status, m_axis_tdata[3:2]);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tick side
    // ------------------------------------------------------------------

    // one tick beat; on acceptance the classifier copy steps and queues its report
    task automatic send_tick(input logic lvl);
        int r;
        r = idle_on ? $urandom_range(0, 99) : 0;
        if (r >= 60) begin
            s_axis_tvalid <= 1'b0;
            if (r == 99) begin
                // hold off until the block has caught up completely
                do @(posedge i_clk); while (pending_reports.size() != 0);
            end else begin
                repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 40))
                    @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, lvl};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_reports.push_back(classify_tick(lvl));
    endtask

    // a run of ticks at one level, never beyond the item budget
    task automatic send_run(input logic lvl, input int len, input int budget, inout int sent);
        for (int i = 0; i < len && sent < budget; i++) begin
            send_tick(lvl);
            sent++;
        end
    endtask

    // stop sending and wait for every report, then a margin
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // write all three registers on back-to-back edges, block must be idle
    task automatic load_settings(input logic [TICK_W-1:0] period,
                                 input logic [HOLD_W-1:0] thresh,
                                 input logic [ELAPSED_W-1:0] window);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SAMPLE_PERIOD;
        i_cfg_data <= CFG_DAT_W'(period);
        @(posedge i_clk);
        cls_period = period;
        i_cfg_idx  <= REG_HOLD_THRESHOLD;
        i_cfg_data <= CFG_DAT_W'(thresh);
        @(posedge i_clk);
        cls_thresh = thresh;
        i_cfg_idx  <= REG_RELEASE_WINDOW;
        i_cfg_data <= CFG_DAT_W'(window);
        @(posedge i_clk);
        cls_window = window;
        i_cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: no query inside a few ticks, status stays one click
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // query every tick: both presses reach the hold status, no short press; the long hold repeats long presses
    task automatic test_press_kinds();
        logic [10:0] seq;
        seq = 11'b011111_0110;   // sent from bit 0 up
        wait_drained();
        load_settings(8'd0, 8'd2, 16'd1);
        for (int i = 0; i < 11; i++)
            send_tick(seq[i]);
    endtask

    // period and threshold of zero, window of zero: long press on every pressed query after the first
    task automatic test_zero_settings();
        wait_drained();
        load_settings(8'd0, 8'd0, 16'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // one long press with threshold 255: the hold count pins at 255 before the
    // window passes, so a long press comes out as soon as it does
    task automatic test_counter_saturation();
        idle_on = 1'b0;
        wait_drained();
        load_settings(8'd0, 8'd255, 16'd300);
        send_tick(1'b0);
        repeat (420) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_drained();
        idle_on = 1'b1;
    endtask

    // one setting, then mostly press / release runs sized in queries, some noise
    task automatic run_phase(input logic [TICK_W-1:0] period,
                             input logic [HOLD_W-1:0] thresh,
                             input logic [ELAPSED_W-1:0] window,
                             input int budget);
        int sent;
        int q;
        int kind;
        sent = 0;
        q    = int'(period) + 1;
        wait_drained();
        load_settings(period, thresh, window);
        idle_on = ($urandom_range(0, 3) != 0);
        while (sent < budget) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                // tap or short hold
                send_run(1'b1, q * $urandom_range(1, int'(thresh) + 4), budget, sent);
                send_run(1'b0, q * $urandom_range(1, 4), budget, sent);
            end else if (kind < 8) begin
                // hold from the threshold to well past it
                send_run(1'b1, q * $urandom_range(int'(thresh), 3 * int'(thresh) + 30),
                         budget, sent);
                send_run(1'b0, q * $urandom_range(1, 3), budget, sent);
            end else if (kind == 8) begin
                // bouncing contact
                for (int i = $urandom_range(1, 12); i > 0 && sent < budget; i--) begin
                    send_tick(1'($urandom_range(0, 1)));
                    sent++;
                end
            end else begin
                // single-tick glitch
                send_run(1'b1, 1, budget, sent);
                send_run(1'b0, $urandom_range(1, 2), budget, sent);
            end
        end
    endtask

    task automatic test_random_presses();
        run_phase(8'd255, 8'd1, 16'd0, 360);       // slowest prescaler
        run_phase(8'd0, 8'd255, 16'd5, 180);       // largest threshold
        run_phase(8'd1, 8'd1, 16'hFFFF, 100);      // window never passes
        repeat (6)
            run_phase(8'($urandom_range(0, 3)), 8'($urandom_range(1, 6)),
                      16'($urandom_range(0, 20)), 100);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_press_kinds();
        test_zero_settings();
        test_counter_saturation();
        test_random_presses();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_button_press_classifier_unit: done, clean");
        end else begin
            $display("tb_button_press_classifier_unit: done, errors");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("tb_button_press_classifier_unit: done, errors");
        $finish;
    end

endmodule

@@ button_press_classifier_unit.f @@
rtl/bpc_pkg.sv
rtl/bpc_query.sv
rtl/button_press_classifier_unit.sv
test/tb_button_press_classifier_unit.sv
